// File: src/grr_pkg.sv
// Shared types and constants for the group reversal reorder block.
// No dependencies; compile first.
package grr_pkg;

    localparam int MAX_GROUP_DEF = 64;
    localparam int VALUE_W       = 60;
    localparam int SIZE_W        = 7;

    typedef enum logic [1:0] {
        ST_FILL,
        ST_READ,
        ST_SHOW
    } grr_state_t;

    // controller -> datapath strobes; addresses travel beside it
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } grr_cmd_t;

endpackage

// File: src/grr_ifs.sv
// Valid/ready channel interfaces for input items and result items.
// Depends on grr_pkg for payload widths.
interface grr_in_if;
    import grr_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               final_element;

    modport source (output valid, output value, output final_element, input ready);
    modport sink   (input valid, input value, input final_element, output ready);
endinterface

interface grr_out_if;
    import grr_pkg::*;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] out_value;
    logic               run_end;
    logic               array_end;

    modport source (output valid, output out_value, output run_end, output array_end,
                    input ready);
    modport sink   (input valid, input out_value, input run_end, input array_end,
                    output ready);
endinterface

// File: src/group_reversal_reorder.sv
// Group reversal reorder top level: buffers a group of values, then emits it reversed.
// After a group's closing beat, ST_READ fetches its first result and ST_SHOW presents it.
// Throughput: one input beat per cycle while filling; readout one beat per cycle
// while results.ready is high; the input stays closed until the group is fully read out.
// Reset (rst_n, async low) empties the group and sets group_size to 1.
// Depends on grr_pkg, grr_ifs, grr_ctrl and grr_datapath.
module group_reversal_reorder #(
    parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [grr_pkg::SIZE_W-1:0] cfg_data,
    grr_in_if.sink                     items,
    grr_out_if.source                  results
);
    import grr_pkg::*;

    localparam int AW = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;

    grr_cmd_t      cmd;
    logic [AW-1:0] wr_addr;
    logic [AW-1:0] rd_addr;

    grr_ctrl #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_valid  (items.valid),
        .in_final  (items.final_element),
        .in_ready  (items.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .run_end   (results.run_end),
        .array_end (results.array_end),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_addr   (rd_addr)
    );

    grr_datapath #(
        .MAX_GROUP (MAX_GROUP),
        .AW        (AW)
    ) u_datapath (
        .clk     (clk),
        .cmd     (cmd),
        .wr_addr (wr_addr),
        .rd_addr (rd_addr),
        .wr_data (items.value),
        .rd_data (results.out_value)
    );

endmodule

// File: src/grr_datapath.sv
// Group store memory and registered read data.
// Depends on grr_pkg; driven by grr_ctrl.
module grr_datapath #(
    parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF,
    parameter int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                       clk,
    input  grr_pkg::grr_cmd_t          cmd,
    input  logic [AW-1:0]              wr_addr,
    input  logic [AW-1:0]              rd_addr,
    input  logic [grr_pkg::VALUE_W-1:0] wr_data,
    output logic [grr_pkg::VALUE_W-1:0] rd_data
);
    import grr_pkg::*;

    logic [VALUE_W-1:0] mem [MAX_GROUP];
    logic [VALUE_W-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // q_reg holds the shown beat until the next read is issued
    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            q_reg <= mem[rd_addr];
        end
    end

    assign rd_data = q_reg;

endmodule

// File: src/grr_ctrl.sv
// Controller: fill count, group size register, readout index and state machine.
// Depends on grr_pkg; commands grr_datapath.
module grr_ctrl #(
    parameter int MAX_GROUP = grr_pkg::MAX_GROUP_DEF,
    parameter int AW        = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [grr_pkg::SIZE_W-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_final,
    output logic                       in_ready,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       run_end,
    output logic                       array_end,
    output grr_pkg::grr_cmd_t          cmd,
    output logic [AW-1:0]              wr_addr,
    output logic [AW-1:0]              rd_addr
);
    import grr_pkg::*;

    localparam int CW = $clog2(MAX_GROUP + 1);
    localparam int SW = (CW > SIZE_W) ? CW : SIZE_W;

    grr_state_t        state_reg, state_next;
    logic [CW-1:0]     fill_reg, fill_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              last_reg, last_next;
    logic              run_end_reg, run_end_next;
    logic              array_end_reg, array_end_next;
    logic [SIZE_W-1:0] size_reg, size_next;

    logic [SW-1:0]     size_ext;
    logic [SW-1:0]     eff_size;
    logic [CW-1:0]     fill_plus;
    logic              accept;
    logic              group_done;

    always_comb
    begin
        size_ext = SW'(size_reg);
        if (size_ext == '0)
            eff_size = SW'(1);
        else if (size_ext > SW'(MAX_GROUP))
            eff_size = SW'(MAX_GROUP);
        else
            eff_size = size_ext;
    end

    // fill_reg stays below MAX_GROUP, so the increment cannot wrap
    assign fill_plus  = fill_reg + CW'(1);
    assign accept     = (state_reg == ST_FILL) && in_valid;
    assign group_done = (SW'(fill_plus) >= eff_size) || in_final;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (accept && group_done)
                    state_next = ST_READ;
            end
            ST_READ:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                if (out_ready && (idx_reg == '0))
                    state_next = ST_FILL;
            end
            default:
            begin
                state_next = ST_FILL;
            end
        endcase
    end

    // outputs and datapath commands
    always_comb
    begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        wr_addr   = fill_reg[AW-1:0];
        rd_addr   = idx_reg;
        case (state_reg)
            ST_FILL:
            begin
                in_ready   = 1'b1;
                cmd.wr_en  = in_valid;
            end
            ST_READ:
            begin
                cmd.rd_en = 1'b1;
            end
            ST_SHOW:
            begin
                out_valid = 1'b1;
                // fetch the next beat while this one is taken
                if (out_ready && (idx_reg != '0))
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = idx_reg - AW'(1);
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // counters and flags
    always_comb
    begin
        fill_next      = fill_reg;
        idx_next       = idx_reg;
        last_next      = last_reg;
        run_end_next   = run_end_reg;
        array_end_next = array_end_reg;
        size_next      = cfg_we ? cfg_data : size_reg;

        if (accept)
        begin
            if (group_done)
            begin
                fill_next = '0;
                idx_next  = fill_reg[AW-1:0];
                last_next = in_final;
            end
            else
            begin
                fill_next = fill_plus;
            end
        end

        if (cmd.rd_en)
        begin
            idx_next       = rd_addr;
            run_end_next   = (rd_addr == '0);
            array_end_next = (rd_addr == '0) && last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_FILL;
            fill_reg      <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            run_end_reg   <= 1'b0;
            array_end_reg <= 1'b0;
            size_reg      <= SIZE_W'(1);
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            idx_reg       <= idx_next;
            last_reg      <= last_next;
            run_end_reg   <= run_end_next;
            array_end_reg <= array_end_next;
            size_reg      <= size_next;
        end
    end

    assign run_end   = run_end_reg;
    assign array_end = array_end_reg;

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input and output open in the same cycle");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < CW'(MAX_GROUP))
        else $error("fill count reached group store depth");

    a_array_end_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && array_end |-> run_end)
        else $error("array end without run end");

    a_run_end_release: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && run_end |=> in_ready && !out_valid)
        else $error("controller did not return to fill after run end");

    a_drain_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_end |=> out_valid)
        else $error("readout stopped inside a group");

endmodule

// File: tb/tb_top.sv
// Self-checking bench for group_reversal_reorder: a clocked driver and monitor,
// a group reversal predictor, bursty input and a patterned, stalling output side.
// Depends on grr_pkg, grr_ifs and the group_reversal_reorder RTL.
module tb_top;
    import grr_pkg::*;

    localparam logic [63:0] VALUE_MAX  = 64'd1000000000000000000;
    localparam int          SETTLE     = 8;
    localparam int          HOLD_LEN   = 300;
    localparam int          IDLE_LIMIT = 2000;
    localparam int          RAND_ITEMS = 350;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
    } element_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               run_end;
        logic               array_end;
    } result_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [SIZE_W-1:0] cfg_data;

    grr_in_if  items ();
    grr_out_if results ();

    group_reversal_reorder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .items    (items),
        .results  (results)
    );

    // elements waiting to be sent, and results the block still owes
    element_t item_q[$];
    result_t  reversed_q[$];

    // predictor state
    logic [VALUE_W-1:0] group_copy [MAX_GROUP_DEF];
    int                 fill = 0;
    logic [SIZE_W-1:0]  size_shadow = 1;

    int errors     = 0;
    int out_beats  = 0;
    int idle_count = 0;
    int rand_items = 0;
    bit in_taken   = 0;

    // sender and receiver pacing
    int burst_left = 0;
    int gap_left   = 0;
    int hold_cnt   = 0;
    bit hold_done  = 0;
    int pat_mode   = 0;
    int pat_left   = 0;
    int pat_phase  = 0;

    always #5 clk = ~clk;

    task automatic absorb_element(input logic [VALUE_W-1:0] v, input logic last);
        int      eff;
        result_t r;
        if (size_shadow == 0)
            eff = 1;
        else if (size_shadow > MAX_GROUP_DEF)
            eff = MAX_GROUP_DEF;
        else
            eff = int'(size_shadow);
        if (fill < MAX_GROUP_DEF)
        begin
            group_copy[fill] = v;
            fill++;
        end
        if (fill < eff && !last)
            return;
        for (int k = fill - 1; k >= 0; k--)
        begin
            r.value     = group_copy[k];
            r.run_end   = (k == 0);
            r.array_end = (k == 0) && last;
            reversed_q.insert(reversed_q.size(), r);
        end
        fill = 0;
    endtask

    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: r = r % 64;
            1: r = VALUE_MAX - (r % 64);
            default: r = r % (VALUE_MAX + 1);
        endcase
        return r[VALUE_W-1:0];
    endfunction

    function automatic int effective(input logic [SIZE_W-1:0] sz);
        if (sz == 0)
            return 1;
        if (sz > MAX_GROUP_DEF)
            return MAX_GROUP_DEF;
        return int'(sz);
    endfunction

    task automatic queue_element(input logic [VALUE_W-1:0] v, input logic last);
        element_t e;
        e.value = v;
        e.last  = last;
        item_q.insert(item_q.size(), e);
    endtask

    // everything sent, every result back, then let a pending readout finish
    task automatic drain();
        while (!(item_q.size() == 0 && !items.valid && reversed_q.size() == 0))
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_group_size(input logic [SIZE_W-1:0] sz);
        drain();
        @(negedge clk);
        cfg_we      <= 1'b1;
        cfg_data    <= sz;
        size_shadow  = sz;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // whole arrays with random content; sometimes an open tail is left behind
    task automatic random_phase(input logic [SIZE_W-1:0] sz, input int arrays_max);
        int eff;
        int len;
        eff = effective(sz);
        write_group_size(sz);
        repeat ($urandom_range(1, arrays_max))
        begin
            if (rand_items < RAND_ITEMS)
            begin
                len = eff * $urandom_range(0, 1) + $urandom_range(1, eff);
                if (len > RAND_ITEMS - rand_items)
                    len = RAND_ITEMS - rand_items;
                for (int i = 0; i < len; i++)
                    queue_element(pick_value(), i == len - 1);
                rand_items += len;
            end
        end
        if ($urandom_range(0, 4) == 0 && rand_items < RAND_ITEMS)
        begin
            len = $urandom_range(1, eff);
            if (len > RAND_ITEMS - rand_items)
                len = RAND_ITEMS - rand_items;
            for (int i = 0; i < len; i++)
                queue_element(pick_value(), 1'b0);
            rand_items += len;
        end
    endtask

    // sender: bursts of random length with random gaps
    always @(negedge clk)
    begin
        logic offer;
        if (rst_n)
        begin
            if (in_taken)
                void'(item_q.pop_front());
            offer = items.valid && !in_taken;
            if (!offer)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (item_q.size() > 0)
                begin
                    offer = 1'b1;
                    if (burst_left > 0)
                        burst_left--;
                    else if ($urandom_range(0, 3) == 0)
                    begin
                        burst_left = $urandom_range(50, 200);
                        gap_left   = 0;
                    end
                    else
                    begin
                        burst_left = $urandom_range(0, 12);
                        gap_left   = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                                 : $urandom_range(0, 6);
                    end
                end
            end
            items.valid <= offer;
            if (offer)
            begin
                items.value         <= item_q[0].value;
                items.final_element <= item_q[0].last;
            end
        end
        else
        begin
            items.valid         <= 1'b0;
            items.value         <= '0;
            items.final_element <= 1'b0;
        end
    end

    // receiver: its own stall patterns, plus one long hold-off while input is queued
    always @(negedge clk)
    begin
        logic rdy;
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            rdy = 1'b0;
        end
        else if (!hold_done && item_q.size() > 40 && out_beats > 20)
        begin
            hold_done = 1;
            hold_cnt  = HOLD_LEN;
            rdy       = 1'b0;
        end
        else
        begin
            if (pat_left == 0)
            begin
                pat_mode = $urandom_range(0, 3);
                pat_left = $urandom_range(5, 80);
            end
            pat_left--;
            pat_phase++;
            case (pat_mode)
                0: rdy = 1'b1;
                1: rdy = $urandom_range(0, 1);
                2: rdy = (pat_phase % 4 == 0);
                default: rdy = (pat_phase % 3 != 0);
            endcase
        end
        results.ready <= rdy;
    end

    // monitor: inputs feed the predictor, outputs are checked against it
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        bit      out_taken;
        in_taken  = items.valid && items.ready;
        out_taken = results.valid && results.ready;
        if (in_taken)
            absorb_element(items.value, items.final_element);
        if (out_taken)
        begin
            out_beats++;
            got.value     = results.out_value;
            got.run_end   = results.run_end;
            got.array_end = results.array_end;
            if (reversed_q.size() == 0)
            begin
                $display("%0t: unexpected beat, expected none, got value %0d",
                         $time, got.value,
                         " run_end %0b array_end %0b", got.run_end, got.array_end);
                errors++;
            end
            else
            begin
                want = reversed_q.pop_front();
                if (got.value !== want.value)
                begin
                    $display("%0t: out_value expected %0d, got %0d",
                             $time, want.value, got.value);
                    errors++;
                end
                if (got.run_end !== want.run_end)
                begin
                    $display("%0t: run_end expected %0b, got %0b",
                             $time, want.run_end, got.run_end);
                    errors++;
                end
                if (got.array_end !== want.array_end)
                begin
                    $display("%0t: array_end expected %0b, got %0b",
                             $time, want.array_end, got.array_end);
                    errors++;
                end
            end
        end
        if (!rst_n || in_taken || out_taken)
            idle_count = 0;
        else
            idle_count++;
        if (idle_count >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        clk      = 1'b0;
        rst_n    = 1'b0;
        cfg_we   = 1'b0;
        cfg_data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset size of one: extremes of value
        queue_element('0, 1'b0);
        queue_element(VALUE_MAX[VALUE_W-1:0], 1'b1);

        // zero acts as one
        write_group_size(7'd0);
        queue_element(60'd1, 1'b0);
        queue_element(VALUE_MAX[VALUE_W-1:0] - 1, 1'b1);

        // full group then a short final group; then final landing on a full group
        write_group_size(7'd3);
        for (int i = 0; i < 5; i++)
            queue_element(pick_value(), i == 4);
        for (int i = 0; i < 3; i++)
            queue_element(pick_value(), i == 2);

        // size lowered below the fill: next beat closes the whole group
        write_group_size(7'd8);
        for (int i = 0; i < 5; i++)
            queue_element(pick_value(), 1'b0);
        write_group_size(7'd2);
        queue_element(pick_value(), 1'b0);
        // final on the first beat of a group
        queue_element(pick_value(), 1'b1);

        // oversized setting, short array
        write_group_size(7'd127);
        for (int i = 0; i < 3; i++)
            queue_element(pick_value(), i == 2);

        // largest groups first, then a random mix weighted to small sizes
        random_phase(7'd64, 1);
        random_phase(7'd127, 1);
        while (rand_items < RAND_ITEMS)
        begin
            case ($urandom_range(0, 7))
                0: random_phase(7'd0, 3);
                1: random_phase(7'($urandom_range(65, 127)), 3);
                2: random_phase(7'd1, 3);
                3: random_phase(7'($urandom_range(9, 64)), 3);
                default: random_phase(7'($urandom_range(2, 8)), 3);
            endcase
        end

        drain();
        repeat (20) @(posedge clk);
        if (errors == 0 && reversed_q.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: filelist.f
src/grr_pkg.sv
src/grr_ifs.sv
src/grr_datapath.sv
src/grr_ctrl.sv
src/group_reversal_reorder.sv
tb/tb_top.sv
